FILE: src/rmd_pkg.sv
`default_nettype none
package rmd_pkg;
	localparam int OPERAND_WIDTH = 32;
	localparam int W = OPERAND_WIDTH;
	// Quotient bits resolved per back-end stage
	localparam int STEPS = 4;
	localparam int NSTAGES = (2 * W - 1 + STEPS - 1) / STEPS;
	localparam int QW = NSTAGES * STEPS;
	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_DIV_ZERO = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	typedef struct packed {
		logic signed [W-1:0] number;
		logic signed [W-1:0] numerator;
		logic signed [W-1:0] denominator;
	} req_t;

	typedef struct packed {
		logic signed [W-1:0] quotient;
		logic [1:0] status;
	} rsp_t;

	// Classified work handed from front to back
	typedef struct packed {
		logic neg;
		logic dz;
		logic [W-1:0] dvs;
		logic [QW-1:0] mag;
	} work_t;
endpackage
`default_nettype wire

FILE: src/rounded_multiply_divide.sv
// Throughput: one item per cycle unless rsp_ready stalls the output; the front
// (3 stages), a 4-entry queue and a 16-stage restoring divider (4 quotient bits
// per stage) plus output register.
// Reset (arst_n low, asynchronous) empties all stages and the queue; data is not cleared.
`default_nettype none
module rounded_multiply_divide import rmd_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_ready,
	input wire req_t req,
	output logic rsp_valid,
	input wire logic rsp_ready,
	output rsp_t rsp
);
	logic push_valid, push_ready, pop_valid, pop_ready;
	work_t push_work, pop_work;

	// Front: take magnitudes, form the product, add half the divisor.
	rmd_front u_front (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.push_valid(push_valid), .push_ready(push_ready), .push_work(push_work)
	);

	// Queue: hold classified items so front and back stall independently.
	rmd_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push_valid(push_valid), .push_ready(push_ready), .push_work(push_work),
		.pop_valid(pop_valid), .pop_ready(pop_ready), .pop_work(pop_work)
	);

	// Back: divide magnitudes, apply sign, flag overflow or zero divisor.
	rmd_back u_back (
		.clk(clk), .arst_n(arst_n),
		.pop_valid(pop_valid), .pop_ready(pop_ready), .pop_work(pop_work),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	a_dz_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_DIV_ZERO |-> rsp.quotient == '1)
		else $error("zero divisor result not all ones");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.status == ST_OK || rsp.status == ST_DIV_ZERO
			|| rsp.status == ST_OVERFLOW))
		else $error("unused status code");
	a_front_flow: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid && !push_ready |-> !req_ready)
		else $error("front accepts while queue full");
endmodule
`default_nettype wire

FILE: src/rmd_front.sv
`default_nettype none
module rmd_front import rmd_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_ready,
	input wire req_t req,
	output logic push_valid,
	input wire logic push_ready,
	output work_t push_work
);
	logic v_s1, v_s2, v_s3;
	logic [W-1:0] a_s1, b_s1, d_s1, d_s2;
	logic neg_s1, dz_s1, neg_s2, dz_s2;
	logic [2*W-1:0] prod_s2;
	work_t work_s3;
	logic adv;

	assign adv = !v_s3 || push_ready;
	assign req_ready = adv;
	assign push_valid = v_s3;
	assign push_work = work_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// magnitudes and sign of the rounded quotient
	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1 <= req.number[W-1] ? W'(-req.number) : W'(req.number);
			b_s1 <= req.numerator[W-1] ? W'(-req.numerator) : W'(req.numerator);
			d_s1 <= req.denominator[W-1] ? W'(-req.denominator) : W'(req.denominator);
			neg_s1 <= (req.number[W-1] ^ req.numerator[W-1] ^ req.denominator[W-1])
				&& (req.number != '0) && (req.numerator != '0);
			dz_s1 <= (req.denominator == '0);
			prod_s2 <= (2*W)'(a_s1) * (2*W)'(b_s1);
			d_s2 <= d_s1;
			neg_s2 <= neg_s1;
			dz_s2 <= dz_s1;
			work_s3.mag <= QW'(prod_s2[2*W-2:0]) + QW'(d_s2[W-1:1]);
			work_s3.dvs <= d_s2;
			work_s3.neg <= neg_s2;
			work_s3.dz <= dz_s2;
		end
	end
endmodule
`default_nettype wire

FILE: src/rmd_queue.sv
`default_nettype none
module rmd_queue import rmd_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push_valid,
	output logic push_ready,
	input wire work_t push_work,
	output logic pop_valid,
	input wire logic pop_ready,
	output work_t pop_work
);
	work_t mem [QDEPTH];
	logic [QAW-1:0] wptr_q, rptr_q;
	logic [QAW:0] cnt_q;
	logic push, pop;

	assign push_ready = (cnt_q != (QAW+1)'(QDEPTH));
	assign pop_valid = (cnt_q != '0);
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;
	assign pop_work = mem[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wptr_q] <= push_work;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop) rptr_q <= rptr_q + 1'b1;
			cnt_q <= cnt_q + (QAW+1)'(push) - (QAW+1)'(pop);
		end
	end
endmodule
`default_nettype wire

FILE: src/rmd_back.sv
`default_nettype none
module rmd_back import rmd_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic pop_valid,
	output logic pop_ready,
	input wire work_t pop_work,
	output logic rsp_valid,
	input wire logic rsp_ready,
	output rsp_t rsp
);
	typedef struct packed {
		logic neg;
		logic dz;
		logic [W-1:0] dvs;
		logic [W-1:0] rem;
		logic [QW-1:0] sh;
	} stg_t;

	function automatic stg_t div_steps(stg_t s);
		stg_t r;
		logic [W:0] t;
		r = s;
		for (int k = 0; k < STEPS; k++) begin
			t = {r.rem, r.sh[QW-1]};
			r.sh = {r.sh[QW-2:0], 1'b0};
			if (t >= {1'b0, r.dvs}) begin
				t = t - {1'b0, r.dvs};
				r.sh[0] = 1'b1;
			end
			r.rem = t[W-1:0];
		end
		return r;
	endfunction

	stg_t stg_s [NSTAGES];
	logic v_s [NSTAGES];
	stg_t head;
	logic rsp_v_q;
	rsp_t rsp_q;
	logic adv;
	logic [QW-1:0] mag, lim, sq;

	assign adv = !rsp_v_q || rsp_ready;
	assign pop_ready = adv;
	assign rsp_valid = rsp_v_q;
	assign rsp = rsp_q;

	always_comb begin
		head.neg = pop_work.neg;
		head.dz = pop_work.dz;
		head.dvs = pop_work.dvs;
		head.rem = '0;
		head.sh = pop_work.mag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NSTAGES; i++) v_s[i] <= 1'b0;
			rsp_v_q <= 1'b0;
		end else if (adv) begin
			v_s[0] <= pop_valid;
			for (int i = 1; i < NSTAGES; i++) v_s[i] <= v_s[i-1];
			rsp_v_q <= v_s[NSTAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			stg_s[0] <= div_steps(head);
			for (int i = 1; i < NSTAGES; i++) stg_s[i] <= div_steps(stg_s[i-1]);
		end
	end

	always_comb begin
		mag = stg_s[NSTAGES-1].sh;
		lim = stg_s[NSTAGES-1].neg ? (QW'(1) << (W-1)) : ((QW'(1) << (W-1)) - QW'(1));
		sq = stg_s[NSTAGES-1].neg ? (~mag + QW'(1)) : mag;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (stg_s[NSTAGES-1].dz) begin
				rsp_q.quotient <= '1;
				rsp_q.status <= ST_DIV_ZERO;
			end else begin
				rsp_q.quotient <= sq[W-1:0];
				rsp_q.status <= (mag > lim) ? ST_OVERFLOW : ST_OK;
			end
		end
	end
endmodule
`default_nettype wire
